// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
// Each macro places one labeled concurrent assertion, sampled on the rising
// clock edge and switched off while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next-cycle assertion failed");

`endif

// ----- sv/pws_pkg.sv -----
`default_nettype none

package pws_pkg;

	// Pre-token classes as they appear on the word_class port.
	localparam logic [2:0] CLS_CONTRACTION = 3'd0;
	localparam logic [2:0] CLS_LETTERS     = 3'd1;
	localparam logic [2:0] CLS_DIGITS      = 3'd2;
	localparam logic [2:0] CLS_SYMBOLS     = 3'd3;
	localparam logic [2:0] CLS_SPACE       = 3'd4;

	// Bytes that take part in the splitting rules.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_V     = 8'h76;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_E     = 8'h65;

	// What the front end is holding back while it waits for lookahead.
	typedef enum logic [1:0] {
		HOLD_NONE,
		HOLD_SPACE,
		HOLD_APOS,
		HOLD_APOS_X
	} hold_t;

	// One released byte with its marks.
	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic [2:0] cls;
	} res_t;

	// All results caused by one request, packed from slot 0 upward.
	typedef struct packed {
		logic [1:0]     count;
		res_t [2:0]     res;
		logic           last;
	} entry_t;

	// Character class in the ASCII C locale; bytes of 128 and up are symbols.
	function automatic logic [2:0] classify(input logic [7:0] b);
		logic [2:0] k;
		if ((b >= 8'd9 && b <= 8'd13) || b == CH_SPACE) begin
			k = CLS_SPACE;
		end else if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
			k = CLS_LETTERS;
		end else if (b >= 8'h30 && b <= 8'h39) begin
			k = CLS_DIGITS;
		end else begin
			k = CLS_SYMBOLS;
		end
		return k;
	endfunction

endpackage

`default_nettype wire

// ----- sv/pretoken_word_splitter_top.sv -----
`default_nettype none

// Pre-token splitter for a byte-wide text stream.
// Text channel: text_valid/text_stall with text_byte and last_byte; one byte
// is taken per cycle while the internal queue has room.
// Word channel: word_valid/word_stall with out_byte, starts_word, word_class,
// run_last and text_end; bytes leave in their original order, each marked
// with its word start and pre-token class. run_last flags the final result
// of one request, text_end the final result of a request with last_byte set.
// A byte that can resolve at once goes through its queue entry and then the
// output register before word_valid shows it. A space or apostrophe is held for
// up to two further bytes of lookahead; last_byte releases everything held.
// Throughput is one result per cycle while word_stall is low, set by the single
// output register; a request releases zero to three results, so bursts of three
// are absorbed by the QUEUE_DEPTH-entry queue while lookahead bytes release nothing.
// While word_stall is high the output holds and the queue fills; text_stall
// rises once the queue is full. Reset empties the queue and drops any held
// lookahead, so the next byte starts a new text.
module pretoken_word_splitter_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       text_valid,
	output logic            text_stall,
	input  wire logic [7:0] text_byte,
	input  wire logic       last_byte,
	output logic            word_valid,
	input  wire logic       word_stall,
	output logic [7:0]      out_byte,
	output logic            starts_word,
	output logic [2:0]      word_class,
	output logic            run_last,
	output logic            text_end
);

	pws_pkg::entry_t wr_entry;
	pws_pkg::entry_t head;
	logic            push;
	logic            pop;
	logic            not_empty;
	logic            full;
	logic            accept;

	// A request is taken whenever the queue can hold its results.
	assign text_stall = full;
	assign accept     = text_valid && !full;

	pws_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text_byte (text_byte),
		.last_byte (last_byte),
		.entry     (wr_entry),
		.push      (push)
	);

	pws_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (full)
	);

	pws_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.not_empty   (not_empty),
		.pop         (pop),
		.word_valid  (word_valid),
		.word_stall  (word_stall),
		.out_byte    (out_byte),
		.starts_word (starts_word),
		.word_class  (word_class),
		.run_last    (run_last),
		.text_end    (text_end)
	);

endmodule

`default_nettype wire

// ----- sv/pws_front.sv -----
`default_nettype none

// Front end: classifies each accepted byte, tracks the lookahead state and
// produces the complete set of results that the byte releases.
module pws_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      text_byte,
	input  wire logic            last_byte,
	output pws_pkg::entry_t      entry,
	output logic                 push
);

	pws_pkg::hold_t hold_q, hold_d;
	logic [7:0]     x_q, x_d;
	logic           seg_q, seg_d;
	logic [2:0]     cls_q, cls_d;

	// Lookahead state; the held letter needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= pws_pkg::HOLD_NONE;
			seg_q  <= 1'b0;
			cls_q  <= pws_pkg::CLS_CONTRACTION;
		end else if (accept) begin
			hold_q <= hold_d;
			seg_q  <= seg_d;
			cls_q  <= cls_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= x_d;
		end
	end

	// Decide what this byte releases and what stays held.
	always_comb begin
		logic [1:0]        n;
		pws_pkg::res_t [2:0] r;
		logic [2:0]        k;
		logic              do_ext;
		logic              stmd;
		logic              rvl;
		logic              done;

		n      = 2'd0;
		r      = '0;
		k      = pws_pkg::classify(text_byte);
		do_ext = 1'b0;
		hold_d = hold_q;
		x_d    = x_q;
		seg_d  = seg_q;
		cls_d  = cls_q;
		stmd   = text_byte == pws_pkg::CH_S || text_byte == pws_pkg::CH_T ||
			text_byte == pws_pkg::CH_M || text_byte == pws_pkg::CH_D;
		rvl    = text_byte == pws_pkg::CH_R || text_byte == pws_pkg::CH_V ||
			text_byte == pws_pkg::CH_L;
		done   = ((x_q == pws_pkg::CH_R || x_q == pws_pkg::CH_V) &&
			text_byte == pws_pkg::CH_E) ||
			(x_q == pws_pkg::CH_L && text_byte == pws_pkg::CH_L);

		unique case (hold_q)
			pws_pkg::HOLD_NONE: begin
				do_ext = 1'b1;
			end
			pws_pkg::HOLD_SPACE: begin
				// The held space joins the run of the new byte.
				r[n] = '{data: pws_pkg::CH_SPACE, start: 1'b1, cls: k};
				n = n + 2'd1;
				r[n] = '{data: text_byte, start: 1'b0, cls: k};
				n = n + 2'd1;
				cls_d  = k;
				seg_d  = 1'b1;
				hold_d = pws_pkg::HOLD_NONE;
			end
			pws_pkg::HOLD_APOS: begin
				if (stmd) begin
					r[n] = '{data: pws_pkg::CH_APOS, start: 1'b1,
						cls: pws_pkg::CLS_CONTRACTION};
					n = n + 2'd1;
					r[n] = '{data: text_byte, start: 1'b0, cls: pws_pkg::CLS_CONTRACTION};
					n = n + 2'd1;
					hold_d = pws_pkg::HOLD_NONE;
					seg_d  = 1'b0;
				end else if (rvl) begin
					x_d    = text_byte;
					hold_d = pws_pkg::HOLD_APOS_X;
				end else begin
					r[n] = '{data: pws_pkg::CH_APOS, start: 1'b1, cls: pws_pkg::CLS_SYMBOLS};
					n = n + 2'd1;
					cls_d  = pws_pkg::CLS_SYMBOLS;
					seg_d  = 1'b1;
					hold_d = pws_pkg::HOLD_NONE;
					do_ext = 1'b1;
				end
			end
			pws_pkg::HOLD_APOS_X: begin
				if (done) begin
					r[n] = '{data: pws_pkg::CH_APOS, start: 1'b1,
						cls: pws_pkg::CLS_CONTRACTION};
					n = n + 2'd1;
					r[n] = '{data: x_q, start: 1'b0, cls: pws_pkg::CLS_CONTRACTION};
					n = n + 2'd1;
					r[n] = '{data: text_byte, start: 1'b0, cls: pws_pkg::CLS_CONTRACTION};
					n = n + 2'd1;
					hold_d = pws_pkg::HOLD_NONE;
					seg_d  = 1'b0;
				end else begin
					// Broken contraction: apostrophe alone, letter opens a letter run.
					r[n] = '{data: pws_pkg::CH_APOS, start: 1'b1, cls: pws_pkg::CLS_SYMBOLS};
					n = n + 2'd1;
					r[n] = '{data: x_q, start: 1'b1, cls: pws_pkg::CLS_LETTERS};
					n = n + 2'd1;
					cls_d  = pws_pkg::CLS_LETTERS;
					seg_d  = 1'b1;
					hold_d = pws_pkg::HOLD_NONE;
					do_ext = 1'b1;
				end
			end
			default: begin
				hold_d = pws_pkg::HOLD_NONE;
			end
		endcase

		// Grow the open run or start a new word with this byte.
		if (do_ext) begin
			if (seg_d && k == cls_d) begin
				r[n] = '{data: text_byte, start: 1'b0, cls: k};
				n = n + 2'd1;
			end else if (text_byte == pws_pkg::CH_SPACE) begin
				hold_d = pws_pkg::HOLD_SPACE;
				seg_d  = 1'b0;
			end else if (text_byte == pws_pkg::CH_APOS) begin
				hold_d = pws_pkg::HOLD_APOS;
				seg_d  = 1'b0;
			end else begin
				r[n] = '{data: text_byte, start: 1'b1, cls: k};
				n = n + 2'd1;
				cls_d = k;
				seg_d = 1'b1;
			end
		end

		// At end of text release whatever is held and return to reset.
		if (last_byte) begin
			unique case (hold_d)
				pws_pkg::HOLD_NONE: begin
				end
				pws_pkg::HOLD_SPACE: begin
					r[n] = '{data: pws_pkg::CH_SPACE, start: 1'b1, cls: pws_pkg::CLS_SPACE};
					n = n + 2'd1;
				end
				pws_pkg::HOLD_APOS: begin
					r[n] = '{data: pws_pkg::CH_APOS, start: 1'b1, cls: pws_pkg::CLS_SYMBOLS};
					n = n + 2'd1;
				end
				pws_pkg::HOLD_APOS_X: begin
					r[n] = '{data: pws_pkg::CH_APOS, start: 1'b1, cls: pws_pkg::CLS_SYMBOLS};
					n = n + 2'd1;
					r[n] = '{data: x_d, start: 1'b1, cls: pws_pkg::CLS_LETTERS};
					n = n + 2'd1;
				end
				default: begin
				end
			endcase
			hold_d = pws_pkg::HOLD_NONE;
			seg_d  = 1'b0;
			cls_d  = pws_pkg::CLS_CONTRACTION;
		end

		entry.count = n;
		entry.res   = r;
		entry.last  = last_byte;
		push        = accept && (n != 2'd0);
	end

endmodule

`default_nettype wire

// ----- sv/pws_queue.sv -----
`default_nettype none

// Short queue between the front and back ends, one request's results per entry.
module pws_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire pws_pkg::entry_t wr_entry,
	input  wire logic            pop,
	output pws_pkg::entry_t      head,
	output logic                 not_empty,
	output logic                 full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pws_pkg::entry_t slot_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign not_empty = count_q != '0;
	assign full      = count_q == CW'(DEPTH);
	assign head      = slot_q[rd_q];

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= wr_entry;
		end
	end

	// Pointers wrap at the last entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/pws_back.sv -----
`default_nettype none

// Back end: walks the results of the head entry one per cycle into the
// output register while it is empty or not stalled.
module pws_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pws_pkg::entry_t head,
	input  wire logic            not_empty,
	output logic                 pop,
	output logic                 word_valid,
	input  wire logic            word_stall,
	output logic [7:0]           out_byte,
	output logic                 starts_word,
	output logic [2:0]           word_class,
	output logic                 run_last,
	output logic                 text_end
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic       load;
	logic       final_slot;
	pws_pkg::res_t cur;

	// Load a new result whenever the output register is empty or draining.
	assign load       = not_empty && (!valid_q || !word_stall);
	assign final_slot = idx_q == (head.count - 2'd1);
	assign cur        = head.res[idx_q];
	assign pop        = load && final_slot;
	assign word_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_slot ? 2'd0 : idx_q + 2'd1;
			end else if (!word_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte    <= cur.data;
			starts_word <= cur.start;
			word_class  <= cur.cls;
			run_last    <= final_slot;
			text_end    <= final_slot && head.last;
		end
	end

endmodule

`default_nettype wire

// ----- sv/pws_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

// Port-level checks on the word channel.
module pws_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       word_valid,
	input wire logic       word_stall,
	input wire logic [7:0] out_byte,
	input wire logic       starts_word,
	input wire logic [2:0] word_class,
	input wire logic       run_last,
	input wire logic       text_end
);

	// A stalled result stays and keeps its payload.
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, word_valid && word_stall, word_valid && $stable(out_byte) && $stable(starts_word) && $stable(word_class) && $stable(run_last) && $stable(text_end))

	// The end of the text always closes a request.
	`ASSERT_SAME(a_end_closes, clk, arst_n, word_valid && text_end, run_last)

	// A contraction always opens with its apostrophe.
	`ASSERT_SAME(a_contraction_head, clk, arst_n, word_valid && starts_word && word_class == pws_pkg::CLS_CONTRACTION, out_byte == pws_pkg::CH_APOS)

	// Inside a digit run only digits follow.
	`ASSERT_SAME(a_digit_run, clk, arst_n, word_valid && !starts_word && word_class == pws_pkg::CLS_DIGITS, out_byte >= 8'h30 && out_byte <= 8'h39)

endmodule

bind pretoken_word_splitter_top pws_checker u_pws_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.word_valid  (word_valid),
	.word_stall  (word_stall),
	.out_byte    (out_byte),
	.starts_word (starts_word),
	.word_class  (word_class),
	.run_last    (run_last),
	.text_end    (text_end)
);

`default_nettype wire
